### sv/fat_block_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FAT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FAT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fba_pkg.sv
// Types and constants of the block allocator.
`default_nettype none
package fba_pkg;

  localparam int NUM_BLOCKS = 4096;
  localparam int ADDR_W     = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
  localparam int STEP_W     = $clog2(NUM_BLOCKS + 2);
  localparam int ENTRY_W    = 16;
  localparam int CMD_W      = 2;
  localparam int BLOCK_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int STATUS_W   = 2;
  localparam int CMP_W      = 17;

  localparam logic [CMP_W-1:0]   NUM_BLOCKS_X = CMP_W'(NUM_BLOCKS);
  localparam logic [ADDR_W-1:0]  LAST_BLOCK   = ADDR_W'(NUM_BLOCKS - 1);
  localparam logic [ENTRY_W-1:0] ENTRY_FREE   = 16'h0000;
  localparam logic [ENTRY_W-1:0] ENTRY_END    = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_FORMAT = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_BROKEN  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLR_INIT,
    ST_IDLE,
    ST_CLR_FMT,
    ST_ALLOC_SCAN,
    ST_ALLOC_LINK,
    ST_FREE_RD,
    ST_FREE_EV,
    ST_READ_EV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### sv/fba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### sv/fat_block_allocator.sv
// Allocation table controller: first-fit run allocator, chain free, entry read, format.
// Steps: alloc scans for a free run, then writes its links; free walks and clears the chain link by link;
//   format clears one table entry a cycle.
// Commands are taken one at a time; the single table RAM port pair sets the pace.
// Reset (sync, rst_n low): a clearing pass writes all NUM_BLOCKS entries, one a cycle,
//   with in_stall high; no result beat is produced for it.
`default_nettype none
`include "fat_block_allocator_defines.svh"
module fat_block_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fba_pkg::CMD_W-1:0]       in_cmd,
  input  wire logic [fba_pkg::BLOCK_W-1:0]     in_block,
  input  wire logic [fba_pkg::COUNT_W-1:0]     in_count,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [fba_pkg::STATUS_W-1:0]    out_status,
  output logic      [fba_pkg::ENTRY_W-1:0]     out_result_value
);
  import fba_pkg::*;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t              state_r,  state_nxt;
  logic [ADDR_W-1:0]   clr_r,    clr_nxt;     // clearing sweep pointer
  logic [ADDR_W-1:0]   addr_q_r, addr_q_nxt;  // address whose data is on ram_rdata
  logic [CNT_W-1:0]    count_r,  count_nxt;   // requested run length
  logic [CNT_W-1:0]    run_r,    run_nxt;     // current free-run length
  logic [ADDR_W-1:0]   wr_ptr_r, wr_ptr_nxt;  // link writer pointer
  logic [ADDR_W-1:0]   end_r,    end_nxt;     // last block of found run
  logic [ADDR_W-1:0]   cur_r,    cur_nxt;     // chain walk position
  logic [STEP_W-1:0]   steps_r,  steps_nxt;   // links followed so far
  status_t             res_status_r, res_status_nxt;
  logic [ENTRY_W-1:0]  res_value_r,  res_value_nxt;
  logic                out_valid_r,  out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ENTRY_W-1:0]  out_value_r,  out_value_nxt;

  // ---------------------------------------------------------------------------
  // Table RAM
  // ---------------------------------------------------------------------------
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  fba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared decode
  // ---------------------------------------------------------------------------
  logic              in_fire;
  logic              out_slot_free;
  logic              blk_ok;
  logic              cnt_ok;
  logic              entry_free;
  logic              link_bad;      // stored link points past the table
  logic [CNT_W-1:0]  run_inc;
  logic              run_hit;
  logic [STEP_W-1:0] steps_inc;
  logic              steps_over;
  logic [ADDR_W-1:0] run_start;
  cmd_t              cmd;

  assign cmd           = cmd_t'(in_cmd);
  assign in_fire       = in_valid && !in_stall;
  assign out_slot_free = !out_valid_r || !out_stall;
  assign blk_ok        = CMP_W'(in_block) < NUM_BLOCKS_X;
  assign cnt_ok        = (in_count != '0) && (CMP_W'(in_count) <= NUM_BLOCKS_X);
  assign entry_free    = ram_rdata == ENTRY_FREE;
  assign link_bad      = CMP_W'(ram_rdata) >= NUM_BLOCKS_X;
  assign run_inc       = entry_free ? run_r + CNT_W'(1) : '0;
  assign run_hit       = run_inc == count_r;
  assign steps_inc     = steps_r + STEP_W'(1);
  assign steps_over    = CMP_W'(steps_inc) > NUM_BLOCKS_X;
  assign run_start     = ADDR_W'(CMP_W'(addr_q_r) + CMP_W'(1) - CMP_W'(count_r));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR_INIT: begin
        if (clr_r == LAST_BLOCK) state_nxt = ST_IDLE;
      end
      ST_CLR_FMT: begin
        if (clr_r == LAST_BLOCK) state_nxt = ST_DONE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_FORMAT: state_nxt = ST_CLR_FMT;
            CMD_ALLOC:  state_nxt = cnt_ok ? ST_ALLOC_SCAN : ST_DONE;
            CMD_FREE:   state_nxt = blk_ok ? ST_FREE_EV : ST_DONE;
            CMD_READ:   state_nxt = blk_ok ? ST_READ_EV : ST_DONE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ALLOC_SCAN: begin
        priority if (run_hit)                  state_nxt = ST_ALLOC_LINK;
        else if (addr_q_r == LAST_BLOCK)       state_nxt = ST_DONE;
        else                                   state_nxt = ST_ALLOC_SCAN;
      end
      ST_ALLOC_LINK: begin
        if (wr_ptr_r == end_r) state_nxt = ST_DONE;
      end
      ST_FREE_RD: state_nxt = ST_FREE_EV;
      ST_FREE_EV: begin
        priority if (entry_free)               state_nxt = ST_DONE;
        else if (ram_rdata == ENTRY_END)       state_nxt = ST_DONE;
        else if (steps_over || link_bad)       state_nxt = ST_DONE;
        else                                   state_nxt = ST_FREE_RD;
      end
      ST_READ_EV: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLR_INIT;
    endcase
  end

  // ---------------------------------------------------------------------------
  // FSM outputs: handshake and RAM control
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = ENTRY_FREE;
    ram_raddr = addr_q_r;
    unique case (state_r)
      ST_CLR_INIT, ST_CLR_FMT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      ST_IDLE: begin
        in_stall  = 1'b0;
        ram_raddr = (cmd == CMD_ALLOC) ? '0 : ADDR_W'(in_block);
      end
      ST_ALLOC_SCAN: ram_raddr = ADDR_W'(CMP_W'(addr_q_r) + CMP_W'(1));
      ST_ALLOC_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = wr_ptr_r;
        ram_wdata = (wr_ptr_r == end_r) ? ENTRY_END
                                        : ENTRY_W'(CMP_W'(wr_ptr_r) + CMP_W'(1));
      end
      ST_FREE_RD: ram_raddr = cur_r;
      ST_FREE_EV: begin
        ram_we    = !entry_free;
        ram_waddr = cur_r;
      end
      ST_READ_EV, ST_DONE: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    clr_nxt        = clr_r;
    addr_q_nxt     = ram_raddr;
    count_nxt      = count_r;
    run_nxt        = run_r;
    wr_ptr_nxt     = wr_ptr_r;
    end_nxt        = end_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    unique case (state_r)
      ST_CLR_INIT, ST_CLR_FMT: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == LAST_BLOCK) begin
          clr_nxt        = '0;
          res_status_nxt = STAT_OK;
          res_value_nxt  = '0;
        end
      end
      ST_IDLE: begin
        count_nxt      = CNT_W'(in_count);
        run_nxt        = '0;
        cur_nxt        = ADDR_W'(in_block);
        steps_nxt      = '0;
        res_value_nxt  = '0;
        res_status_nxt = STAT_OK;
        if (cmd == CMD_ALLOC && !cnt_ok) res_status_nxt = STAT_NOSPACE;
        if ((cmd == CMD_FREE || cmd == CMD_READ) && !blk_ok) res_status_nxt = STAT_BROKEN;
      end
      ST_ALLOC_SCAN: begin
        run_nxt = run_inc;
        if (run_hit) begin
          end_nxt        = addr_q_r;
          wr_ptr_nxt     = run_start;
          res_status_nxt = STAT_OK;
          res_value_nxt  = ENTRY_W'(run_start);
        end else if (addr_q_r == LAST_BLOCK) begin
          res_status_nxt = STAT_NOSPACE;
          res_value_nxt  = '0;
        end
      end
      ST_ALLOC_LINK: wr_ptr_nxt = wr_ptr_r + ADDR_W'(1);
      ST_FREE_EV: begin
        steps_nxt = steps_inc;
        cur_nxt   = ADDR_W'(ram_rdata);
        priority if (entry_free)          res_status_nxt = STAT_BROKEN;
        else if (ram_rdata == ENTRY_END)  res_status_nxt = STAT_OK;
        else if (steps_over || link_bad)  res_status_nxt = STAT_BROKEN;
        else                              res_status_nxt = STAT_OK;
      end
      ST_READ_EV: begin
        res_status_nxt = STAT_OK;
        res_value_nxt  = ram_rdata;
      end
      ST_FREE_RD, ST_DONE: ;
      default: ;
    endcase
  end

  // Output register: a finished result parks in DONE until the slot frees up.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    if (state_r == ST_DONE && out_slot_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_value_nxt  = res_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_q_r     <= addr_q_nxt;
    count_r      <= count_nxt;
    run_r        <= run_nxt;
    wr_ptr_r     <= wr_ptr_nxt;
    end_r        <= end_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FBA_ASSERT_NOW(a_clear_writes_free,
    state_r == ST_CLR_INIT || state_r == ST_CLR_FMT,
    ram_we && ram_wdata == ENTRY_FREE, "clearing pass must write free entries")
  `FBA_ASSERT_NOW(a_link_in_run, state_r == ST_ALLOC_LINK,
    wr_ptr_r <= end_r, "link writer ran past end of run")
  `FBA_ASSERT_NOW(a_err_value_zero, out_valid_r && out_status_r != STAT_OK,
    out_value_r == '0, "error result carries non-zero value")
  `FBA_ASSERT_NEXT(a_busy_after_accept, in_fire,
    state_r != ST_IDLE, "command accepted but controller stayed idle")
  `FBA_ASSERT_NOW(a_walk_bounded, state_r == ST_FREE_EV || state_r == ST_FREE_RD,
    CMP_W'(steps_r) <= NUM_BLOCKS_X, "chain walk exceeded table size")

endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the allocation table controller.
`timescale 1ns / 1ps
module testbench;
  import fba_pkg::*;

  // Expected result beat, one per accepted command
  typedef struct {
    status_t            st;
    logic [ENTRY_W-1:0] val;
  } fat_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd = '0;
  logic [BLOCK_W-1:0]  in_block = '0;
  logic [COUNT_W-1:0]  in_count = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ENTRY_W-1:0]  out_result_value;

  // Shadow copy of the allocation table, updated as each command is accepted
  logic [ENTRY_W-1:0]  table_img [NUM_BLOCKS];
  int                  used_blocks = 0;
  fat_result_t         expected_results [$];
  int                  chain_heads [$];   // starts of runs believed to be live
  fat_result_t         head_exp;
  int                  n_errors = 0;
  int                  send_idle_pct = 0;
  int                  rx_stall_pct = 0;
  int                  hold_len = 0;      // length of a requested hold-off
  int                  hold_reqs = 0;     // hold-offs requested by the tests
  int                  hold_done = 0;     // hold-offs started by the receiver
  int                  hold_left = 0;

  fat_block_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_block         (in_block),
    .in_count         (in_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_value (out_result_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one command to the shadow table and gives its result.
  // ---------------------------------------------------------------------------
  task automatic predict_fat_cmd(input cmd_t c, input logic [BLOCK_W-1:0] b,
                                 input logic [COUNT_W-1:0] n,
                                 output status_t st, output logic [ENTRY_W-1:0] val);
    int run;
    int start;
    int cur;
    int steps;
    bit done;
    logic [ENTRY_W-1:0] e;
    st  = STAT_OK;
    val = '0;
    case (c)
      CMD_FORMAT: begin
        for (int i = 0; i < NUM_BLOCKS; i++) table_img[i] = ENTRY_FREE;
        used_blocks = 0;
      end
      CMD_ALLOC: begin
        // first fit: scan up to and including the last block
        st   = STAT_NOSPACE;
        run  = 0;
        done = 1'b0;
        if (n != 0 && int'(n) <= NUM_BLOCKS) begin
          for (int i = 0; i < NUM_BLOCKS && !done; i++) begin
            run = (table_img[i] == ENTRY_FREE) ? run + 1 : 0;
            if (run == int'(n)) begin
              start = i + 1 - int'(n);
              for (int k = start; k < i; k++) table_img[k] = ENTRY_W'(k + 1);
              table_img[i] = ENTRY_END;
              used_blocks += int'(n);
              st   = STAT_OK;
              val  = ENTRY_W'(start);
              done = 1'b1;
            end
          end
        end
      end
      CMD_FREE: begin
        // walk the chain, freeing as we go; a free entry (start included),
        // a link past the table or an over-long walk counts as broken
        cur   = int'(b);
        steps = 0;
        done  = 1'b0;
        while (!done) begin
          if (cur >= NUM_BLOCKS) begin
            st   = STAT_BROKEN;
            done = 1'b1;
          end else begin
            e = table_img[cur];
            if (e == ENTRY_FREE) begin
              st   = STAT_BROKEN;
              done = 1'b1;
            end else begin
              table_img[cur] = ENTRY_FREE;
              used_blocks--;
              if (e == ENTRY_END) begin
                done = 1'b1;
              end else begin
                steps++;
                if (steps > NUM_BLOCKS) begin
                  st   = STAT_BROKEN;
                  done = 1'b1;
                end else begin
                  cur = int'(e);
                end
              end
            end
          end
        end
      end
      default: begin
        if (int'(b) < NUM_BLOCKS) val = table_img[b];
        else st = STAT_BROKEN;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one command beat. Payload changes on the falling edge; the beat
  // is taken at the first rising edge with in_stall low. Valid is left high
  // so a following beat can go out back to back.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input cmd_t c, input logic [BLOCK_W-1:0] b,
                          input logic [COUNT_W-1:0] n);
    int gap;
    fat_result_t r;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_block <= b;
    in_count <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_fat_cmd(c, b, n, r.st, r.val);
    expected_results.push_back(r);
    if (c == CMD_FORMAT) chain_heads.delete();
    if (c == CMD_ALLOC && r.st == STAT_OK) chain_heads.push_back(int'(r.val));
  endtask

  // Drop valid, let every expected beat arrive, then watch for strays
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Receiver: random stall, or a forced hold-off while hold_left runs down
  always @(negedge clk) begin
    if (hold_done != hold_reqs) begin
      hold_done <= hold_reqs;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Result checker: every accepted beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d value %0h",
               out_status, out_result_value);
        n_errors++;
      end else begin
        head_exp = expected_results.pop_front();
        if (out_status !== head_exp.st) begin
          $error("status: expected %0d, got %0d", head_exp.st, out_status);
          n_errors++;
        end
        if (out_result_value !== head_exp.val) begin
          $error("result_value: expected %0h, got %0h", head_exp.val, out_result_value);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Table must read back empty after the clearing pass
  task automatic test_reset_state;
    send_cmd(CMD_READ, '0, '0);
    send_cmd(CMD_READ, BLOCK_W'(NUM_BLOCKS - 1), '1);
    send_cmd(CMD_READ, BLOCK_W'($urandom), COUNT_W'($urandom));
    drain();
  endtask

  // Zero and oversized counts, a run over the whole table, full table
  task automatic test_alloc_limits;
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_ALLOC, '1, '1);                          // 8191
    send_cmd(CMD_ALLOC, '0, COUNT_W'(NUM_BLOCKS + 1));
    send_cmd(CMD_ALLOC, '0, COUNT_W'(NUM_BLOCKS));        // whole table
    send_cmd(CMD_READ, '0, '0);
    send_cmd(CMD_READ, BLOCK_W'(NUM_BLOCKS - 2), '0);
    send_cmd(CMD_READ, BLOCK_W'(NUM_BLOCKS - 1), '0);
    send_cmd(CMD_ALLOC, '0, COUNT_W'(1));                 // table full
    send_cmd(CMD_FREE, '0, '1);                           // longest chain
    send_cmd(CMD_FREE, '0, '0);                           // start already free
    drain();
  endtask

  // Free from mid-chain, then from the head into the freed part; a run
  // that only fits against the last block; format of a busy table
  task automatic test_chain_cases;
    send_cmd(CMD_ALLOC, '0, COUNT_W'(5));
    send_cmd(CMD_ALLOC, '0, COUNT_W'(3));
    send_cmd(CMD_FREE, BLOCK_W'(2), '0);
    send_cmd(CMD_FREE, '0, '0);
    send_cmd(CMD_READ, BLOCK_W'(1), '0);
    send_cmd(CMD_ALLOC, '0, COUNT_W'(NUM_BLOCKS - 8));
    send_cmd(CMD_READ, BLOCK_W'(NUM_BLOCKS - 1), '0);
    send_cmd(CMD_FORMAT, '1, '1);
    send_cmd(CMD_READ, BLOCK_W'(8), '0);
    drain();
  endtask

  // Receiver holds off for a long stretch while commands keep coming,
  // so the result stage backs up and in_stall rises
  task automatic test_backpressure;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    hold_len      = 400;
    hold_reqs++;
    for (int j = 0; j < 16; j++) begin
      if (j % 2 == 0) send_cmd(CMD_ALLOC, BLOCK_W'($urandom), COUNT_W'($urandom_range(4, 1)));
      else send_cmd(CMD_READ, BLOCK_W'($urandom_range(31)), COUNT_W'($urandom));
    end
    drain();
  endtask

  // Mostly well-formed alloc/free/read traffic near the bottom of the table,
  // with stray frees, bad counts and the odd format and very long run
  task automatic run_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
    int r;
    int idx;
    logic [COUNT_W-1:0] n;
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    for (int j = 0; j < n_items; j++) begin
      r = $urandom_range(99);
      // keep the table lightly used so scans stay short
      if (used_blocks > 300) r = (chain_heads.size() > 0) ? 40 : 0;
      if (r == 0) begin
        send_cmd(CMD_FORMAT, BLOCK_W'($urandom), COUNT_W'($urandom));
      end else if (r < 36) begin
        n = ($urandom_range(99) == 0) ? COUNT_W'($urandom_range(NUM_BLOCKS, 1024))
                                      : COUNT_W'($urandom_range(16, 1));
        send_cmd(CMD_ALLOC, BLOCK_W'($urandom), n);
      end else if (r < 60) begin
        if (chain_heads.size() == 0) begin
          send_cmd(CMD_READ, BLOCK_W'($urandom_range(63)), COUNT_W'($urandom));
        end else begin
          idx = $urandom_range(chain_heads.size() - 1);
          send_cmd(CMD_FREE, BLOCK_W'(chain_heads[idx]), COUNT_W'($urandom));
          chain_heads.delete(idx);
        end
      end else if (r < 80) begin
        send_cmd(CMD_READ, ($urandom_range(3) == 0) ? BLOCK_W'($urandom)
                                                    : BLOCK_W'($urandom_range(511)),
                 COUNT_W'($urandom));
      end else if (r < 88) begin
        // stray free: may land mid-chain or on a free block
        send_cmd(CMD_FREE, BLOCK_W'($urandom_range(511)), COUNT_W'($urandom));
      end else if (r < 92) begin
        n = ($urandom_range(1) == 0) ? '0 : COUNT_W'($urandom_range(8191, NUM_BLOCKS + 1));
        send_cmd(CMD_ALLOC, BLOCK_W'($urandom), n);
      end else begin
        if (chain_heads.size() == 0) begin
          send_cmd(CMD_READ, BLOCK_W'($urandom), COUNT_W'($urandom));
        end else begin
          idx = $urandom_range(chain_heads.size() - 1);
          send_cmd(CMD_READ, BLOCK_W'(chain_heads[idx]), COUNT_W'($urandom));
        end
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++) table_img[i] = ENTRY_FREE;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_alloc_limits();
    test_chain_cases();
    test_backpressure();
    run_random_traffic(440, 0, 0);
    run_random_traffic(440, 56, 0);
    run_random_traffic(440, 0, 56);
    run_random_traffic(440, 34, 34);

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #64_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
